// File: hw/rtl/lmb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lmb_pkg: level meter ballistics shared types and constants
// Request and response payload structs, register map, fixed-point limits.
// ----------------------------------------------------------------------------
package lmb_pkg;

   typedef struct packed {
      logic [15:0] elapsed_time;
      logic [15:0] request_level;
      logic        is_playing;
      logic        ping_load;
      logic [15:0] ping_value;
      logic        clip_clear;
   } req_type;

   typedef struct packed {
      logic signed [15:0] shown_db;
      logic signed [15:0] peak_db;
      logic               clip_flag;
      logic [1:0]         colour_band;
   } rsp_type;

   localparam int          CSR_ADDR_BITS = 3;
   localparam logic        REG_FLOOR_DB  = 1'b0;

   localparam logic signed [15:0] FLOOR_DB_RESET = -16'sd24576;
   localparam logic signed [15:0] DB_MAX         = 16'sd3072;
   localparam logic signed [15:0] CLIP_THRESH    = -16'sd13;
   localparam logic signed [15:0] BAND_HIGH_DB   = -16'sd768;
   localparam logic signed [15:0] BAND_MID_DB    = -16'sd3072;

   localparam logic [17:0] HOLD_UNITS = 18'd78643;

   // 11/20 as a Q24 reciprocal, exact for every 16-bit elapsed time
   localparam logic [23:0] PING_DECAY_RECIP = 24'd9227471;
   // 20*log10(2) in Q16
   localparam logic signed [19:0] LOG2_DB_Q16 = 20'sd394566;

   localparam logic [1:0] BAND_LOW  = 2'd0;
   localparam logic [1:0] BAND_MID  = 2'd1;
   localparam logic [1:0] BAND_HIGH = 2'd2;

endpackage
`default_nettype wire

// File: hw/rtl/level_meter_ballistics.sv
`default_nettype none
// ----------------------------------------------------------------------------
// level_meter_ballistics: peak program meter with peak hold
// Four-stage pipeline: ping decay and level select, log2 table lookup with
// interpolation, dB scaling and floor clamp, then display and peak ballistics.
// ----------------------------------------------------------------------------
// Each request is one meter tick. Its result is registered through stages
// A, B and C and is offered on rsp_valid from the stage D registers. A new
// request can be accepted every cycle while the response side keeps up;
// the four registered stages set the latency, and the ping and ballistic
// state each close within one stage so throughput is one tick per clock
// unless the response side stalls. When it stalls, stages fill up and
// req_ready drops only once no bubble is left. floor_db is written through
// the csr port and must only be changed while no tick is in flight.
module level_meter_ballistics
   import lmb_pkg::*;
#(
   parameter int LOG_TABLE_BITS = 8
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire req_type                  req_payload,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output rsp_type                       rsp_payload,
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [31:0]              csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);

   localparam int TBL_SIZE = (1 << LOG_TABLE_BITS) + 1;
   localparam int REM_BITS = 15 - LOG_TABLE_BITS;

   function automatic logic [23:0] log2_frac(input int unsigned i);
      logic [63:0] x;
      logic [23:0] r;
      x = 64'((1 << LOG_TABLE_BITS) + i) << (30 - LOG_TABLE_BITS);
      r = '0;
      for (int k = 23; k >= 0; k--) begin
         x = (x * x) >> 30;
         if (x >= (64'd2 << 30)) begin
            x    = x >> 1;
            r[k] = 1'b1;
         end
      end
      return r;
   endfunction

   logic [24:0] lut [TBL_SIZE];

   for (genvar gi = 0; gi < TBL_SIZE; gi++) begin : g_lut
      if (gi == TBL_SIZE - 1) begin : g_last
         assign lut[gi] = 25'd1 << 24;
      end else begin : g_entry
         assign lut[gi] = {1'b0, log2_frac(gi)};
      end
   end

   // configuration
   logic signed [15:0] floor_ff;
   logic               csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_FLOOR_DB) ?
                       {{16{floor_ff[15]}}, floor_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff <= FLOOR_DB_RESET;
      end else if (csr_wr && csr_paddr[2] == REG_FLOOR_DB) begin
         floor_ff <= csr_pwdata[15:0];
      end
   end

   // stage valids and enables
   logic va_ff, vb_ff, vc_ff, rsp_valid_ff;
   logic en_a, en_b, en_c, en_d;

   assign en_d      = ~rsp_valid_ff | rsp_ready;
   assign en_c      = ~vc_ff | en_d;
   assign en_b      = ~vb_ff | en_c;
   assign en_a      = ~va_ff | en_b;
   assign req_ready = en_a;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff        <= 1'b0;
         vb_ff        <= 1'b0;
         vc_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en_a) va_ff <= req_valid;
         if (en_b) vb_ff <= va_ff;
         if (en_c) vc_ff <= vb_ff;
         if (en_d) rsp_valid_ff <= vc_ff;
      end
   end

   // stage A: ping load and decay, level select
   logic [15:0] ping_ff, ping_start, ping_in, dec, lvl_in, lvl_a_ff;
   logic [39:0] dec_prod;
   logic [19:0] fall_prod;
   logic [18:0] pfall_prod;
   logic [12:0] fall_a_ff, fall_b_ff, fall_c_ff;
   logic [11:0] pfall_a_ff, pfall_b_ff, pfall_c_ff;
   logic [15:0] dt_a_ff, dt_b_ff, dt_c_ff;
   logic        clr_a_ff, clr_b_ff, clr_c_ff;
   logic        accept;

   assign accept = req_valid & en_a;

   always_comb begin
      ping_start = req_payload.ping_load ? req_payload.ping_value : ping_ff;
      dec_prod   = 40'(req_payload.elapsed_time) * 40'(PING_DECAY_RECIP);
      dec        = dec_prod[39:24];
      ping_in    = (ping_start > dec) ? ping_start - dec : 16'd0;
      if (!req_payload.is_playing) begin
         lvl_in = 16'd0;
      end else begin
         lvl_in = (req_payload.request_level > ping_in) ?
                  req_payload.request_level : ping_in;
      end
      fall_prod  = 20'(req_payload.elapsed_time) * 20'd15;
      pfall_prod = 19'(req_payload.elapsed_time) * 19'd7;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ping_ff <= 16'd0;
      end else if (accept) begin
         ping_ff <= ping_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         lvl_a_ff   <= lvl_in;
         fall_a_ff  <= fall_prod[19:7];
         pfall_a_ff <= pfall_prod[18:7];
         dt_a_ff    <= req_payload.elapsed_time;
         clr_a_ff   <= req_payload.clip_clear;
      end
   end

   // stage B: normalize, table lookup, interpolate
   logic [3:0]                  p_in, p_b_ff;
   logic [15:0]                 norm;
   logic [LOG_TABLE_BITS-1:0]   idx;
   logic [LOG_TABLE_BITS:0]     idx_hi;
   logic [REM_BITS-1:0]         rem;
   logic [24:0]                 t_lo, t_hi, f_in, f_b_ff;
   logic [24+REM_BITS:0]        interp;
   logic                        zero_b_ff;

   always_comb begin
      p_in = 4'd0;
      for (int k = 0; k < 16; k++) begin
         if (lvl_a_ff[k]) p_in = 4'(k);
      end
      norm   = lvl_a_ff << (4'd15 - p_in);
      idx    = norm[14 -: LOG_TABLE_BITS];
      rem    = norm[REM_BITS-1:0];
      idx_hi = {1'b0, idx} + 1'b1;
      t_lo   = lut[idx];
      t_hi   = lut[idx_hi];
      interp = (25 + REM_BITS)'(t_hi - t_lo) * (25 + REM_BITS)'(rem);
      f_in   = t_lo + 25'(interp >> REM_BITS);
   end

   always_ff @(posedge clock) begin
      if (en_b) begin
         p_b_ff     <= p_in;
         f_b_ff     <= f_in;
         zero_b_ff  <= (lvl_a_ff == 16'd0);
         fall_b_ff  <= fall_a_ff;
         pfall_b_ff <= pfall_a_ff;
         dt_b_ff    <= dt_a_ff;
         clr_b_ff   <= clr_a_ff;
      end
   end

   // stage C: scale to dB, clamp
   logic signed [5:0]  pexp;
   logic signed [29:0] log_q24;
   logic signed [49:0] db_prod;
   logic signed [17:0] db_raw;
   logic signed [15:0] floor_sat, db_in, db_c_ff;

   always_comb begin
      pexp      = $signed({2'b00, p_b_ff}) - 6'sd14;
      log_q24   = $signed({pexp, 24'd0}) + $signed({5'd0, f_b_ff});
      db_prod   = log_q24 * LOG2_DB_Q16;
      db_prod   = db_prod + (50'sd1 <<< 31);
      db_raw    = db_prod[49:32];
      floor_sat = (floor_ff > DB_MAX) ? DB_MAX : floor_ff;
      if (zero_b_ff) begin
         db_in = floor_sat;
      end else if (db_raw < 18'(floor_ff)) begin
         db_in = floor_sat;
      end else if (db_raw > 18'(DB_MAX)) begin
         db_in = DB_MAX;
      end else begin
         db_in = db_raw[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en_c) begin
         db_c_ff    <= db_in;
         fall_c_ff  <= fall_b_ff;
         pfall_c_ff <= pfall_b_ff;
         dt_c_ff    <= dt_b_ff;
         clr_c_ff   <= clr_b_ff;
      end
   end

   // stage D: display fall, peak hold and fall, clip latch
   logic signed [15:0] disp_ff, disp_in, peak_ff, peak_in;
   logic signed [16:0] disp_t, peak_t;
   logic [17:0]        timer_ff, timer_in;
   logic [18:0]        timer_sum;
   logic               clip_ff, clip_in;
   logic               advance;
   logic [1:0]         band;

   assign advance = vc_ff & en_d;

   always_comb begin
      disp_t = $signed({disp_ff[15], disp_ff}) - $signed({4'd0, fall_c_ff});
      if (db_c_ff >= disp_ff) begin
         disp_in = db_c_ff;
      end else begin
         disp_in = (disp_t > 17'(db_c_ff)) ? disp_t[15:0] : db_c_ff;
      end

      timer_sum = {1'b0, timer_ff} + {3'd0, dt_c_ff};
      peak_t    = $signed({peak_ff[15], peak_ff}) - $signed({5'd0, pfall_c_ff});
      if (db_c_ff >= peak_ff) begin
         peak_in  = db_c_ff;
         timer_in = 18'd0;
      end else begin
         timer_in = timer_sum[18] ? '1 : timer_sum[17:0];
         if (timer_in > HOLD_UNITS) begin
            peak_in = (peak_t > 17'(db_c_ff)) ? peak_t[15:0] : db_c_ff;
         end else begin
            peak_in = peak_ff;
         end
      end

      clip_in = (clr_c_ff ? 1'b0 : clip_ff) | (db_c_ff > CLIP_THRESH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         disp_ff  <= FLOOR_DB_RESET;
         peak_ff  <= FLOOR_DB_RESET;
         timer_ff <= 18'd0;
         clip_ff  <= 1'b0;
      end else if (advance) begin
         disp_ff  <= disp_in;
         peak_ff  <= peak_in;
         timer_ff <= timer_in;
         clip_ff  <= clip_in;
      end
   end

   always_comb begin
      if (disp_ff >= BAND_HIGH_DB) begin
         band = BAND_HIGH;
      end else if (disp_ff >= BAND_MID_DB) begin
         band = BAND_MID;
      end else begin
         band = BAND_LOW;
      end
   end

   // hold the response from the ballistic state until taken
   always_comb begin
      rsp_payload.shown_db    = disp_ff;
      rsp_payload.peak_db     = peak_ff;
      rsp_payload.clip_flag   = clip_ff;
      rsp_payload.colour_band = band;
   end

endmodule
`default_nettype wire
